// ===== sv/amsc_pkg.sv =====
// shared constants, types and state codes for the magnitude step counter
`timescale 1ns / 1ps

package amsc_pkg;

   localparam int AXIS_BITS_DEF  = 13;
   localparam int FRAC_BITS_DEF  = 4;
   localparam int COUNT_BITS_DEF = 16;

   localparam int THRESH_BITS  = 13;
   localparam int AVG_BITS     = 17;
   localparam int MAG_OUT_BITS = 13;
   localparam int CNT_OUT_BITS = 16;

   localparam logic [THRESH_BITS-1:0] THRESH_RESET = 13'd1000;

   localparam int NUM_AXES = 3;
   localparam int SEL_BITS = 2;

   localparam logic [SEL_BITS-1:0] SEL_X = 2'd0;
   localparam logic [SEL_BITS-1:0] SEL_Y = 2'd1;
   localparam logic [SEL_BITS-1:0] SEL_Z = 2'd2;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SQUARE,
      ST_ROOT,
      ST_UPDATE
   } amsc_state_type;

   typedef struct packed {
      logic                load;
      logic                sq_en;
      logic                sq_first;
      logic                sq_last;
      logic [SEL_BITS-1:0] sel;
      logic                root_step;
      logic                update;
   } amsc_cmd_type;

endpackage

// ===== sv/amsc_if.sv =====
// request, response and register write channel interfaces
`timescale 1ns / 1ps

interface amsc_req_if #(
   parameter int AXIS_BITS = amsc_pkg::AXIS_BITS_DEF
);
   logic                        valid;
   logic                        ready;
   logic signed [AXIS_BITS-1:0] accel_x;
   logic signed [AXIS_BITS-1:0] accel_y;
   logic signed [AXIS_BITS-1:0] accel_z;

   modport source (output valid, output accel_x, output accel_y, output accel_z, input ready);
   modport sink (input valid, input accel_x, input accel_y, input accel_z, output ready);
endinterface

interface amsc_rsp_if;
   logic                              valid;
   logic                              ready;
   logic [amsc_pkg::MAG_OUT_BITS-1:0] magnitude;
   logic [amsc_pkg::MAG_OUT_BITS-1:0] average_level;
   logic [amsc_pkg::CNT_OUT_BITS-1:0] step_count;

   modport source (output valid, output magnitude, output average_level, output step_count,
                   input ready);
   modport sink (input valid, input magnitude, input average_level, input step_count,
                 output ready);
endinterface

interface amsc_csr_if;
   logic                             valid;
   logic                             ready;
   logic [amsc_pkg::THRESH_BITS-1:0] step_threshold;

   modport source (output valid, output step_threshold, input ready);
   modport sink (input valid, input step_threshold, output ready);
endinterface

// ===== sv/amsc_ctrl.sv =====
// sequencing state machine for square, root and update phases
`timescale 1ns / 1ps

module amsc_ctrl #(
   parameter int AXIS_BITS = amsc_pkg::AXIS_BITS_DEF,
   parameter int FRAC_BITS = amsc_pkg::FRAC_BITS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output amsc_pkg::amsc_cmd_type cmd
);

   localparam int ROOT_W = AXIS_BITS + FRAC_BITS + 1;
   localparam int CNT_W  = $clog2(ROOT_W);

   amsc_pkg::amsc_state_type state_ff, state_in;
   logic [CNT_W-1:0]         cnt_ff, cnt_in;
   logic                     out_valid_ff, out_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= amsc_pkg::ST_IDLE;
         cnt_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_comb begin
      state_in      = state_ff;
      cnt_in        = cnt_ff;
      req_ready     = 1'b0;
      cmd           = '0;
      cmd.sel       = cnt_ff[amsc_pkg::SEL_BITS-1:0];
      case (state_ff)
         amsc_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               cnt_in   = '0;
               state_in = amsc_pkg::ST_SQUARE;
            end
         end
         amsc_pkg::ST_SQUARE: begin
            cmd.sq_en    = 1'b1;
            cmd.sq_first = (cnt_ff == '0);
            cmd.sq_last  = (cnt_ff == CNT_W'(amsc_pkg::NUM_AXES - 1));
            if (cmd.sq_last) begin
               cnt_in   = '0;
               state_in = amsc_pkg::ST_ROOT;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         amsc_pkg::ST_ROOT: begin
            cmd.root_step = 1'b1;
            if (cnt_ff == CNT_W'(ROOT_W - 1)) begin
               cnt_in   = '0;
               state_in = amsc_pkg::ST_UPDATE;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         amsc_pkg::ST_UPDATE: begin
            if (!out_valid_ff || rsp_ready) begin
               cmd.update = 1'b1;
               state_in   = amsc_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = amsc_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      if (cmd.update) begin
         out_valid_in = 1'b1;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   assign rsp_valid = out_valid_ff;

endmodule

// ===== sv/amsc_dp.sv =====
// datapath: shared squarer, bit-serial square root, average and step counter
`timescale 1ns / 1ps

module amsc_dp #(
   parameter int AXIS_BITS  = amsc_pkg::AXIS_BITS_DEF,
   parameter int FRAC_BITS  = amsc_pkg::FRAC_BITS_DEF,
   parameter int COUNT_BITS = amsc_pkg::COUNT_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  amsc_pkg::amsc_cmd_type              cmd,
   input  logic signed [AXIS_BITS-1:0]         accel_x,
   input  logic signed [AXIS_BITS-1:0]         accel_y,
   input  logic signed [AXIS_BITS-1:0]         accel_z,
   input  logic                                csr_write,
   input  logic [amsc_pkg::THRESH_BITS-1:0]    csr_data,
   output logic [amsc_pkg::MAG_OUT_BITS-1:0]   magnitude,
   output logic [amsc_pkg::MAG_OUT_BITS-1:0]   average_level,
   output logic [amsc_pkg::CNT_OUT_BITS-1:0]   step_count
);

   localparam int SQ_W   = 2 * AXIS_BITS + 1;
   localparam int ROOT_W = AXIS_BITS + FRAC_BITS + 1;
   localparam int RAD_W  = 2 * ROOT_W;
   localparam int REM_W  = ROOT_W + 2;
   localparam int AVG_W  = amsc_pkg::AVG_BITS;
   localparam int SUM_W  = ((ROOT_W > AVG_W) ? ROOT_W : AVG_W) + 1;
   localparam int THR_W  = amsc_pkg::THRESH_BITS + FRAC_BITS;
   localparam int CMP_W  = (THR_W > AVG_W) ? THR_W : AVG_W;

   logic [AXIS_BITS-1:0]             ax_ff, ay_ff, az_ff;
   logic [AXIS_BITS-1:0]             op;
   logic [2*AXIS_BITS-1:0]           sq;
   logic [SQ_W-1:0]                  acc_ff, acc_in, acc_sum;
   logic [RAD_W-1:0]                 rad_ff, rad_in;
   logic [REM_W-1:0]                 rem_ff, rem_in, rem_sh, trial, diff;
   logic                             ge;
   logic [ROOT_W-1:0]                root_ff, root_in;
   logic [amsc_pkg::THRESH_BITS-1:0] thresh_ff;
   logic [AVG_W-1:0]                 avg_ff, avg_in;
   logic                             above_ff, above_in;
   logic [COUNT_BITS-1:0]            total_ff, total_in;
   logic [SUM_W-1:0]                 sum;
   logic [CMP_W-1:0]                 avg_cmp, thr_cmp;
   logic [amsc_pkg::MAG_OUT_BITS-1:0] mag_out_ff, avg_out_ff;
   logic [amsc_pkg::CNT_OUT_BITS-1:0] cnt_out_ff;

   function automatic logic [AXIS_BITS-1:0] abs_axis(input logic [AXIS_BITS-1:0] v);
      abs_axis = v[AXIS_BITS-1] ? (~v + 1'b1) : v;
   endfunction

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         ax_ff <= abs_axis($unsigned(accel_x));
         ay_ff <= abs_axis($unsigned(accel_y));
         az_ff <= abs_axis($unsigned(accel_z));
      end
   end

   // shared squarer, one axis per cycle
   always_comb begin
      case (cmd.sel)
         amsc_pkg::SEL_X: op = ax_ff;
         amsc_pkg::SEL_Y: op = ay_ff;
         amsc_pkg::SEL_Z: op = az_ff;
         default:         op = az_ff;
      endcase
   end

   assign sq      = op * op;
   assign acc_sum = cmd.sq_first ? SQ_W'(sq) : acc_ff + SQ_W'(sq);
   assign acc_in  = cmd.sq_en ? acc_sum : acc_ff;

   // restoring root, one result bit per cycle
   assign rem_sh = {rem_ff[ROOT_W-1:0], rad_ff[RAD_W-1 -: 2]};
   assign trial  = {root_ff, 2'b01};
   assign ge     = (rem_sh >= trial);
   assign diff   = rem_sh - trial;

   always_comb begin
      rad_in  = rad_ff;
      rem_in  = rem_ff;
      root_in = root_ff;
      if (cmd.sq_last) begin
         rad_in  = RAD_W'(acc_sum) << (2 * FRAC_BITS);
         rem_in  = '0;
         root_in = '0;
      end else if (cmd.root_step) begin
         rad_in  = rad_ff << 2;
         rem_in  = ge ? diff : rem_sh;
         root_in = {root_ff[ROOT_W-2:0], ge};
      end
   end

   always_ff @(posedge clock) begin
      acc_ff  <= acc_in;
      rad_ff  <= rad_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
   end

   // average and threshold detector
   assign sum     = SUM_W'(avg_ff) + SUM_W'(root_ff);
   assign avg_in  = AVG_W'(sum >> 1);
   assign avg_cmp = CMP_W'(avg_in);
   assign thr_cmp = CMP_W'(thresh_ff) << FRAC_BITS;

   always_comb begin
      above_in = above_ff;
      total_in = total_ff;
      if ((avg_cmp > thr_cmp) && !above_ff) begin
         above_in = 1'b1;
         if (total_ff != '1) begin
            total_in = total_ff + 1'b1;
         end
      end else if (avg_cmp < thr_cmp) begin
         above_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         thresh_ff <= amsc_pkg::THRESH_RESET;
         avg_ff    <= '0;
         above_ff  <= 1'b0;
         total_ff  <= '0;
      end else begin
         if (csr_write) begin
            thresh_ff <= csr_data;
         end
         if (cmd.update) begin
            avg_ff   <= avg_in;
            above_ff <= above_in;
            total_ff <= total_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.update) begin
         mag_out_ff <= amsc_pkg::MAG_OUT_BITS'(root_ff >> FRAC_BITS);
         avg_out_ff <= amsc_pkg::MAG_OUT_BITS'(avg_in >> FRAC_BITS);
         cnt_out_ff <= amsc_pkg::CNT_OUT_BITS'(total_in);
      end
   end

   assign magnitude     = mag_out_ff;
   assign average_level = avg_out_ff;
   assign step_count    = cnt_out_ff;

endmodule

// ===== sv/accel_magnitude_step_counter.sv =====
// top level of the accelerometer magnitude step counter
`timescale 1ns / 1ps

// Usage: each request on req_chan carries one x/y/z sample in milli-g. The block
// squares the three axes on one shared multiplier, takes the floor square root
// with FRAC_BITS fractional bits one result bit per cycle, then updates the
// halving average, the armed flag and the saturating step count.
// A request is taken only in the idle state, so a new request is not accepted
// until the previous one has passed its update step.
// rsp_chan is an output register: the next request is accepted while a
// result still waits; if it is still not taken when the next one is done,
// the block holds in its update step until rsp_chan.ready.
// csr_chan writes step_threshold at any handshake and is always ready;
// write it only while no request is in flight.
// Reset (synchronous, active high) clears the average, the count and the
// armed flag, drops rsp_chan.valid and sets the threshold to 1000.

module accel_magnitude_step_counter #(
   parameter int AXIS_BITS  = amsc_pkg::AXIS_BITS_DEF,
   parameter int FRAC_BITS  = amsc_pkg::FRAC_BITS_DEF,
   parameter int COUNT_BITS = amsc_pkg::COUNT_BITS_DEF
) (
   input logic         clock,
   input logic         reset,
   amsc_req_if.sink    req_chan,
   amsc_rsp_if.source  rsp_chan,
   amsc_csr_if.sink    csr_chan
);

   amsc_pkg::amsc_cmd_type cmd;

   assign csr_chan.ready = 1'b1;

   amsc_ctrl #(
      .AXIS_BITS (AXIS_BITS),
      .FRAC_BITS (FRAC_BITS)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .cmd       (cmd)
   );

   amsc_dp #(
      .AXIS_BITS  (AXIS_BITS),
      .FRAC_BITS  (FRAC_BITS),
      .COUNT_BITS (COUNT_BITS)
   ) u_dp (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .accel_x       (req_chan.accel_x),
      .accel_y       (req_chan.accel_y),
      .accel_z       (req_chan.accel_z),
      .csr_write     (csr_chan.valid && csr_chan.ready),
      .csr_data      (csr_chan.step_threshold),
      .magnitude     (rsp_chan.magnitude),
      .average_level (rsp_chan.average_level),
      .step_count    (rsp_chan.step_count)
   );

   // one request in flight at a time
   a_busy_after_accept : assert property (@(posedge clock) disable iff (reset)
      (req_chan.valid && req_chan.ready) |=> !req_chan.ready)
      else $error("request taken while busy");

   // a fresh result only appears after the update step
   a_result_after_update : assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_chan.valid) |-> $past(!req_chan.ready))
      else $error("result appeared outside update");

   a_reset_clears_valid : assert property (@(posedge clock)
      reset |=> !rsp_chan.valid)
      else $error("result valid after reset");

endmodule
